// ===== rtl/core/ssrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared widths, codes and word types for the stack slot reuse pool.
// ----------------------------------------------------------------------------
package ssrp_pkg;

   localparam int POOL_DEPTH = 16;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int ADDR_W     = 16;
   localparam int POS_W      = 24;
   localparam int GEN_W      = 32;

   localparam logic FUNC_FREE    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [GEN_W-1:0]  gen_type;

   typedef struct packed {
      addr_type address;
      pos_type  freed_pos;
      gen_type  generation;
   } entry_type;

   typedef struct packed {
      logic     func;
      addr_type slot_address;
      pos_type  instr_pos;
      gen_type  generation;
      logic     eligible;
      logic     floor_given;
      addr_type floor_addr;
      logic     ceiling_given;
      addr_type ceiling_addr;
   } req_type;

   typedef struct packed {
      logic     reused;
      addr_type granted_address;
      logic     pool_full;
   } rsp_type;

   typedef struct packed {
      logic      en;
      idx_type   addr;
      entry_type data;
   } ram_wr_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
   } ram_rd_type;

endpackage

// ===== rtl/core/ssrp_entry_ram.sv =====
// ----------------------------------------------------------------------------
// ssrp_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssrp_entry_ram (
   input  logic                   clock,
   input  ssrp_pkg::ram_wr_type   wr,
   input  ssrp_pkg::ram_rd_type   rd,
   output ssrp_pkg::entry_type    rd_data
);
   import ssrp_pkg::*;

   entry_type mem [POOL_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssrp_ctrl
// Sequencer: insert into lowest empty entry, refuse a barred request, or scan
// the store one entry per cycle to prune and pick the lowest-address candidate.
// ----------------------------------------------------------------------------
module ssrp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable_reuse,
   input  logic                 req_valid,
   input  ssrp_pkg::req_type    req,
   output logic                 req_ready,
   output logic                 done_valid,
   output ssrp_pkg::rsp_type    done_data,
   input  logic                 out_free,
   output ssrp_pkg::ram_wr_type ram_wr,
   output ssrp_pkg::ram_rd_type ram_rd,
   input  ssrp_pkg::entry_type  ram_rd_data
);
   import ssrp_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [POOL_DEPTH-1:0] valid_ff, valid_in;
   req_type               req_ff, req_in;
   cnt_type               issue_cnt_ff, issue_cnt_in;
   logic                  eval_ff, eval_in;
   idx_type               eval_idx_ff, eval_idx_in;
   logic                  best_found_ff, best_found_in;
   idx_type               best_idx_ff, best_idx_in;
   addr_type              best_addr_ff, best_addr_in;
   rsp_type               rsp_ff, rsp_in;

   logic    free_found;
   idx_type free_idx;
   logic    ent_live;
   logic    prune;
   logic    cand;
   logic    issue_done;

   // lowest-index empty entry
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = POOL_DEPTH - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(k);
         end
      end
   end

   assign ent_live = valid_ff[eval_idx_ff];
   assign prune    = (req_ff.floor_given && (ram_rd_data.address < req_ff.floor_addr))
                  || (req_ff.ceiling_given && (ram_rd_data.address >= req_ff.ceiling_addr))
                  || (ram_rd_data.generation != req_ff.generation);
   // strict compare keeps the lowest index on equal addresses
   assign cand     = ent_live && !prune && (ram_rd_data.freed_pos < req_ff.instr_pos)
                  && (!best_found_ff || (ram_rd_data.address < best_addr_ff));
   assign issue_done = (issue_cnt_ff == CNT_W'(POOL_DEPTH));

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      req_in        = req_ff;
      issue_cnt_in  = issue_cnt_ff;
      eval_in       = 1'b0;
      eval_idx_in   = eval_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_addr_in  = best_addr_ff;
      rsp_in        = rsp_ff;
      ram_wr        = '0;
      ram_rd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req;
               rsp_in = '0;
               if (req.func == FUNC_FREE) begin
                  if (free_found) begin
                     valid_in[free_idx]       = 1'b1;
                     ram_wr.en                = 1'b1;
                     ram_wr.addr              = free_idx;
                     ram_wr.data.address      = req.slot_address;
                     ram_wr.data.freed_pos    = req.instr_pos;
                     ram_wr.data.generation   = req.generation;
                  end else begin
                     rsp_in.pool_full = 1'b1;
                  end
                  state_in = ST_FINISH;
               end else if (!enable_reuse || !req.eligible) begin
                  state_in = ST_FINISH;
               end else begin
                  issue_cnt_in  = '0;
                  best_found_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!issue_done) begin
               ram_rd.en    = 1'b1;
               ram_rd.addr  = issue_cnt_ff[IDX_W-1:0];
               eval_in      = 1'b1;
               eval_idx_in  = issue_cnt_ff[IDX_W-1:0];
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (eval_ff) begin
               if (ent_live && prune) begin
                  valid_in[eval_idx_ff] = 1'b0;
               end
               if (cand) begin
                  best_found_in = 1'b1;
                  best_idx_in   = eval_idx_ff;
                  best_addr_in  = ram_rd_data.address;
               end
            end
            if (issue_done && !eval_ff) begin
               if (best_found_ff) begin
                  valid_in[best_idx_ff]  = 1'b0;
                  rsp_in.reused          = 1'b1;
                  rsp_in.granted_address = best_addr_ff;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         eval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         eval_ff  <= eval_in;
      end
      req_ff        <= req_in;
      issue_cnt_ff  <= issue_cnt_in;
      eval_idx_ff   <= eval_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_addr_ff  <= best_addr_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_FINISH);
   assign done_data  = rsp_ff;

endmodule

// ===== rtl/core/stack_slot_reuse_pool_core.sv =====
// ----------------------------------------------------------------------------
// stack_slot_reuse_pool_core
// Pool of freed stack slots with lowest-address reuse grant.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready channel. req_func selects a free word (store the
//   slot address, freeing position and generation in the lowest empty entry)
//   or a reuse request (prune stale entries, grant the lowest-address entry
//   freed before req_instr_pos). Every word yields exactly one rsp_* word.
//   csr_write_enable/csr_write_data write enable_reuse; write only when idle.
// Flow:
//   One word at a time. A free word or a refused request goes straight to
//   the finish state; a scanned request first reads the entry memory, one
//   entry per cycle, then waits for the registered read data, retires the
//   grant and loads rsp_*. The next word is taken once the result has moved
//   to rsp_*; the single read port of the entry memory sets the scan length.
// Reset:
//   Synchronous, active high. Empties the pool (all valid bits clear), sets
//   enable_reuse to 1 and drops any pending response.
// Stall:
//   rsp_* is a register. While it waits for rsp_ready the core still accepts
//   and works on the next word, and holds that word's result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module stack_slot_reuse_pool_core (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [15:0]            req_slot_address,
   input  logic [23:0]            req_instr_pos,
   input  logic [31:0]            req_generation,
   input  logic                   req_eligible,
   input  logic                   req_floor_given,
   input  logic [15:0]            req_floor_addr,
   input  logic                   req_ceiling_given,
   input  logic [15:0]            req_ceiling_addr,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_reused,
   output logic [15:0]            rsp_granted_address,
   output logic                   rsp_pool_full,
   // control register
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data
);
   import ssrp_pkg::*;

   req_type    req;
   rsp_type    done_data;
   logic       done_valid;
   logic       out_free;
   ram_wr_type ram_wr;
   ram_rd_type ram_rd;
   entry_type  ram_rd_data;

   logic       enable_reuse_ff, enable_reuse_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // pack the request word
   assign req.func          = req_func;
   assign req.slot_address  = req_slot_address;
   assign req.instr_pos     = req_instr_pos;
   assign req.generation    = req_generation;
   assign req.eligible      = req_eligible;
   assign req.floor_given   = req_floor_given;
   assign req.floor_addr    = req_floor_addr;
   assign req.ceiling_given = req_ceiling_given;
   assign req.ceiling_addr  = req_ceiling_addr;

   // control register: written at once, no read-back
   assign enable_reuse_in = csr_write_enable ? csr_write_data : enable_reuse_ff;

   // output register: load when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_reuse_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         enable_reuse_ff <= enable_reuse_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   ssrp_entry_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   ssrp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .enable_reuse (enable_reuse_ff),
      .req_valid    (req_valid),
      .req          (req),
      .req_ready    (req_ready),
      .done_valid   (done_valid),
      .done_data    (done_data),
      .out_free     (out_free),
      .ram_wr       (ram_wr),
      .ram_rd       (ram_rd),
      .ram_rd_data  (ram_rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reused          = rsp_data_ff.reused;
   assign rsp_granted_address = rsp_data_ff.granted_address;
   assign rsp_pool_full       = rsp_data_ff.pool_full;

endmodule

// ===== rtl/core/ssrp_checker.sv =====
// ----------------------------------------------------------------------------
// ssrp_checker
// Port-level checks for the stack slot reuse pool, bound to the top level.
// ----------------------------------------------------------------------------
module ssrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_reused,
   input logic [15:0] rsp_granted_address,
   input logic        rsp_pool_full
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reused)
         && $stable(rsp_granted_address) && $stable(rsp_pool_full))
      else $error("response word changed while stalled");

   // a grant and a dropped free never share one word
   a_grant_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_reused && rsp_pool_full))
      else $error("reused and pool_full both set");

   // no grant means a zero address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reused |-> rsp_granted_address == 16'd0)
      else $error("address given without a grant");

   // drop any pending response at reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one word in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

endmodule

bind stack_slot_reuse_pool_core ssrp_checker u_ssrp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_reused          (rsp_reused),
   .rsp_granted_address (rsp_granted_address),
   .rsp_pool_full       (rsp_pool_full)
);

// ===== test/stack_slot_reuse_pool_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_slot_reuse_pool_core_test
// Self-checking bench for the stack slot reuse pool. A queue-fed driver pushes
// free and reuse words with random gaps, a monitor stalls the response side at
// random and compares every response word, field by field, with the result
// that a local copy of the pool computes when the request word is accepted.
// ----------------------------------------------------------------------------
module stack_slot_reuse_pool_core_test;
   import ssrp_pkg::*;

   // All block inputs start from known values.
   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic        req_func          = FUNC_FREE;
   addr_type    req_slot_address  = '0;
   pos_type     req_instr_pos     = '0;
   gen_type     req_generation    = '0;
   logic        req_eligible      = 1'b0;
   logic        req_floor_given   = 1'b0;
   addr_type    req_floor_addr    = '0;
   logic        req_ceiling_given = 1'b0;
   addr_type    req_ceiling_addr  = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic        rsp_reused;
   addr_type    rsp_granted_address;
   logic        rsp_pool_full;
   logic        csr_write_enable  = 1'b0;
   logic        csr_write_data    = 1'b0;

   // Local copy of the pool and of enable_reuse.
   logic        pool_live [POOL_DEPTH] = '{default: 1'b0};
   addr_type    pool_addr [POOL_DEPTH];
   pos_type     pool_pos  [POOL_DEPTH];
   gen_type     pool_gen  [POOL_DEPTH];
   logic        reuse_on;

   req_type     word_backlog [$];   // words waiting for the driver
   rsp_type     due_outcomes [$];   // predicted responses, oldest first
   req_type     in_flight;          // word currently shown on req_*

   int          send_gap;
   int          stall_left;
   int          gap_pct;
   int          stall_pct;
   bit          quiet;              // no idling on either side
   int          errors     = 0;
   int          words_seen = 0;

   stack_slot_reuse_pool_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_slot_address    (req_slot_address),
      .req_instr_pos       (req_instr_pos),
      .req_generation      (req_generation),
      .req_eligible        (req_eligible),
      .req_floor_given     (req_floor_given),
      .req_floor_addr      (req_floor_addr),
      .req_ceiling_given   (req_ceiling_given),
      .req_ceiling_addr    (req_ceiling_addr),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_reused          (rsp_reused),
      .rsp_granted_address (rsp_granted_address),
      .rsp_pool_full       (rsp_pool_full),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // Compute the response to one accepted word and advance the pool copy.
   function automatic rsp_type apply_to_pool(req_type w);
      rsp_type r;
      int      best;
      r    = '0;
      best = -1;
      if (w.func == FUNC_FREE) begin
         // Take the lowest empty entry; flag the drop if there is none.
         r.pool_full = 1'b1;
         for (int k = 0; k < POOL_DEPTH; k++) begin
            if (!pool_live[k]) begin
               pool_live[k] = 1'b1;
               pool_addr[k] = w.slot_address;
               pool_pos[k]  = w.instr_pos;
               pool_gen[k]  = w.generation;
               r.pool_full  = 1'b0;
               break;
            end
         end
         return r;
      end
      // Refused requests leave the pool untouched.
      if (!reuse_on || !w.eligible) begin
         return r;
      end
      // Drop entries out of bounds or from another generation.
      for (int k = 0; k < POOL_DEPTH; k++) begin
         if (pool_live[k] &&
             ((w.floor_given && pool_addr[k] < w.floor_addr) ||
              (w.ceiling_given && pool_addr[k] >= w.ceiling_addr) ||
              pool_gen[k] != w.generation)) begin
            pool_live[k] = 1'b0;
         end
      end
      // Lowest address freed strictly earlier wins; strict compare keeps
      // the lowest index on equal addresses.
      for (int k = 0; k < POOL_DEPTH; k++) begin
         if (pool_live[k] && pool_pos[k] < w.instr_pos &&
             (best < 0 || pool_addr[k] < pool_addr[best])) begin
            best = k;
         end
      end
      if (best >= 0) begin
         pool_live[best]   = 1'b0;
         r.reused          = 1'b1;
         r.granted_address = pool_addr[best];
      end
      return r;
   endfunction

   // Append one word to the driver's backlog.
   function automatic void queue_word(req_type w);
      word_backlog.insert(word_backlog.size(), w);
   endfunction

   // Fully random word: every field, used or ignored, gets random bits.
   function automatic req_type noise_word();
      logic [127:0] raw;
      req_type      w;
      raw = {$urandom, $urandom, $urandom, $urandom};
      w   = raw[$bits(req_type)-1:0];
      return w;
   endfunction

   function automatic req_type free_word(addr_type a, pos_type p, gen_type g);
      req_type w;
      w              = noise_word();
      w.func         = FUNC_FREE;
      w.slot_address = a;
      w.instr_pos    = p;
      w.generation   = g;
      return w;
   endfunction

   function automatic req_type ask_word(pos_type p, gen_type g, logic elig,
                                        logic fl_on, addr_type fl,
                                        logic ce_on, addr_type ce);
      req_type w;
      w               = noise_word();
      w.func          = FUNC_REQUEST;
      w.instr_pos     = p;
      w.generation    = g;
      w.eligible      = elig;
      w.floor_given   = fl_on;
      w.floor_addr    = fl;
      w.ceiling_given = ce_on;
      w.ceiling_addr  = ce;
      return w;
   endfunction

   // Half the picks fall in a tight cluster so that ties and bound hits are common.
   function automatic addr_type pick_addr();
      case ($urandom_range(0, 7))
         0: begin
            return 16'h0000;
         end
         1: begin
            return 16'hFFFF;
         end
         2, 3: begin
            return addr_type'($urandom);
         end
         default: begin
            return 16'h4000 + addr_type'($urandom_range(0, 15)) * 16'd4;
         end
      endcase
   endfunction

   function automatic gen_type pick_gen();
      if ($urandom_range(0, 3) == 0) begin
         return gen_type'($urandom);
      end
      return gen_type'($urandom_range(0, 3));
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] word %0d: %s is %0h, expected %0h",
               $realtime, words_seen, what, got, want);
      errors++;
   endtask

   // Random traffic: runs of frees and requests that share a generation and
   // a rising position, so that grants actually happen, plus noise.
   task automatic queue_random_words(int count);
      gen_type gen_now;
      pos_type pos_now;
      int      roll;
      int      made;
      req_type w;
      gen_now = pick_gen();
      pos_now = pos_type'($urandom_range(0, 4095));
      made    = 0;
      while (made < count) begin
         if ($urandom_range(0, 39) == 0) begin
            gen_now = pick_gen();
         end
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            // burst of frees to run the pool full
            repeat ($urandom_range(8, 18)) begin
               queue_word(free_word(pick_addr(), pos_now, gen_now));
               made++;
            end
         end else begin
            if (roll < 48) begin
               w = free_word(pick_addr(), pos_now,
                             ($urandom_range(0, 9) == 0) ? pick_gen() : gen_now);
            end else if (roll < 90) begin
               w = ask_word(($urandom_range(0, 9) == 0) ? pos_type'($urandom) :
                               pos_now + pos_type'($urandom_range(0, 1)),
                            ($urandom_range(0, 9) == 0) ? pick_gen() : gen_now,
                            $urandom_range(0, 9) != 0,
                            $urandom_range(0, 2) == 0, pick_addr(),
                            $urandom_range(0, 2) == 0, pick_addr());
            end else begin
               w = noise_word();
            end
            queue_word(w);
            made++;
         end
         pos_now += pos_type'($urandom_range(0, 2));
      end
   endtask

   // Wait until every word has been sent and answered, then a short pause.
   task automatic settle();
      do begin
         @(negedge clock);
      end while (word_backlog.size() != 0 || req_valid || due_outcomes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reuse_enable(logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      reuse_on = value;
      @(negedge clock);
   endtask

   // Driver: predict on accept, then show the next word or hold a gap.
   always @(posedge clock) begin : drive_req
      logic show;
      show = req_valid;
      if (reset) begin
         show     = 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            due_outcomes.insert(due_outcomes.size(), apply_to_pool(in_flight));
            show = 1'b0;
         end
         if (!show) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (word_backlog.size() > 0) begin
               if (!quiet && $urandom_range(0, 99) < gap_pct) begin
                  // this cycle is the first of the gap
                  send_gap = $urandom_range(1, 19) - 1;
               end else begin
                  in_flight         = word_backlog.pop_front();
                  show              = 1'b1;
                  req_func          <= in_flight.func;
                  req_slot_address  <= in_flight.slot_address;
                  req_instr_pos     <= in_flight.instr_pos;
                  req_generation    <= in_flight.generation;
                  req_eligible      <= in_flight.eligible;
                  req_floor_given   <= in_flight.floor_given;
                  req_floor_addr    <= in_flight.floor_addr;
                  req_ceiling_given <= in_flight.ceiling_given;
                  req_ceiling_addr  <= in_flight.ceiling_addr;
               end
            end
         end
      end
      req_valid <= show;
   end

   // Monitor: check each accepted response word, then pick the next ready.
   always @(posedge clock) begin : watch_rsp
      logic    take;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_outcomes.size() == 0) begin
            flag_mismatch("unexpected word",
                          32'({rsp_reused, rsp_granted_address, rsp_pool_full}), '0);
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_reused !== want.reused) begin
               flag_mismatch("reused", 32'(rsp_reused), 32'(want.reused));
            end
            if (rsp_granted_address !== want.granted_address) begin
               flag_mismatch("granted_address", 32'(rsp_granted_address),
                             32'(want.granted_address));
            end
            if (rsp_pool_full !== want.pool_full) begin
               flag_mismatch("pool_full", 32'(rsp_pool_full), 32'(want.pool_full));
            end
         end
         words_seen++;
      end
      if (reset) begin
         take       = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         take = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 19) - 1;
         take       = 1'b0;
      end else begin
         take = 1'b1;
      end
      rsp_ready <= take;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("stack_slot_reuse_pool_core regression: fail");
      $finish;
   end

   initial begin : run_plan
      gen_type  g_top;
      pos_type  p_top;
      quiet      = 1'b0;
      gap_pct    = 20;
      stall_pct  = 20;
      reuse_on   = 1'b1;
      g_top = 32'hFFFF_FFFF;
      p_top = 24'hFF_FFFF;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reuse enabled from reset.
      queue_word(free_word(16'h8000, 24'd10, g_top));
      queue_word(free_word(16'h8000, 24'd5, g_top));
      queue_word(free_word(16'hFFFF, 24'hFF_FFFE, g_top));
      queue_word(free_word(16'h0000, 24'd20, g_top));
      // not eligible: refused, nothing pruned
      queue_word(ask_word(p_top, g_top, 1'b0, 1'b1, 16'hFFFF,
                          1'b1, 16'h0000));
      // equal addresses: lower index wins; later free not yet eligible
      queue_word(ask_word(24'd11, g_top, 1'b1, 1'b0, 16'hFFFF,
                          1'b0, 16'h0000));
      // freed at exactly the current position: no grant
      queue_word(ask_word(24'd5, g_top, 1'b1, 1'b0, 16'h0000,
                          1'b0, 16'h0000));
      // both bounds prune the extremes, the middle entry is granted
      queue_word(ask_word(p_top, g_top, 1'b1, 1'b1, 16'h0001,
                          1'b1, 16'hFFFF));
      // empty pool
      queue_word(ask_word(p_top, g_top, 1'b1, 1'b0, 16'h0000,
                          1'b0, 16'h0000));
      // run the pool full, then one more free is dropped
      for (int k = 0; k <= POOL_DEPTH; k++) begin
         queue_word(free_word(addr_type'($urandom), pos_type'(k), '0));
      end
      // another generation prunes everything
      queue_word(ask_word(p_top, 32'd1, 1'b1, 1'b0, 16'h0000,
                          1'b0, 16'h0000));
      settle();

      // Reuse off: request refused and the stored entry survives.
      write_reuse_enable(1'b0);
      queue_word(free_word(16'h1234, 24'd0, 32'd7));
      queue_word(ask_word(24'd100, 32'd9, 1'b1, 1'b1, 16'hFFFF,
                          1'b1, 16'h0000));
      settle();
      write_reuse_enable(1'b1);
      queue_word(ask_word(24'd1, 32'd7, 1'b1, 1'b0, 16'h0000,
                          1'b0, 16'h0000));
      settle();

      // Random phases; one runs with reuse off, the last one without idling.
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 1) begin
            write_reuse_enable(1'b0);
         end else if (ph == 2) begin
            write_reuse_enable(1'b1);
         end
         case ($urandom_range(0, 2))
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 10;
               stall_pct = 10;
            end
            default: begin
               gap_pct   = 40;
               stall_pct = 40;
            end
         endcase
         quiet = (ph == 4);
         queue_random_words((ph == 1) ? 150 : (ph == 4) ? 300 : 250);
         settle();
      end

      // Let any stray response show up before the verdict.
      repeat (30) @(negedge clock);
      if (errors == 0) begin
         $display("stack_slot_reuse_pool_core regression: pass");
      end else begin
         $display("stack_slot_reuse_pool_core regression: fail");
      end
      $finish;
   end

endmodule
